### rtl/smcd_pkg.sv
// Shared constants and types of the serial motor command decoder.
`default_nettype none
package smcd_pkg;

  localparam int MotorCount = 3;
  localparam int FrameLen   = 2 * MotorCount;
  localparam int PosW       = $clog2(FrameLen);
  localparam int ByteW      = 8;
  localparam int WordW      = 2 * ByteW;
  localparam int DutyW      = 16;

  // command bytes
  localparam logic [ByteW-1:0] GoByte   = 8'h67;
  localparam logic [ByteW-1:0] StopByte = 8'h73;
  localparam logic [ByteW-1:0] SyncByte = 8'h75;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [DutyW-1:0] duty_t;

  // state after one item, as seen by the result stage
  typedef struct packed {
    logic                        brake;
    logic                        echo;
    logic [MotorCount-1:0][WordW-1:0] words;
  } smcd_frame_t;

endpackage
`default_nettype wire

### rtl/smcd_intf.sv
// Handshake channels of the decoder: received bytes in, motor commands out.
`default_nettype none
interface smcd_in_if;
  logic                valid;
  logic                ready;
  logic [7:0]          rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smcd_out_if;
  logic        valid;
  logic        ready;
  logic        brake_active;
  logic        dir_first;
  logic        dir_second;
  logic        dir_third;
  logic [15:0] duty_first;
  logic [15:0] duty_second;
  logic [15:0] duty_third;
  logic        echo_valid;

  modport source (
    output valid, output brake_active, output dir_first, output dir_second,
    output dir_third, output duty_first, output duty_second, output duty_third,
    output echo_valid, input ready
  );
  modport sink (
    input valid, input brake_active, input dir_first, input dir_second,
    input dir_third, input duty_first, input duty_second, input duty_third,
    input echo_valid, output ready
  );
endinterface
`default_nettype wire

### rtl/serial_motor_command_decoder_unit.sv
// Top level of the serial motor command decoder.
//
//   port    dir  payload                                     notes
//   rx_i    in   rx_byte                                     one received byte per item
//   cmd_o   out  brake, dir x3, duty x3, echo_valid          one result per byte
//
// One byte per cycle sustained while the receiver takes each result.
// Stage one registers the byte; the decode, frame update and the 5/3 scaling
// by reciprocal multiply sit between it and the result register.
// Reset clears the frame position, stored bytes, latched words and brake flag.
// A stalled result holds stage one; a new byte is still taken while stage one
// is empty or moves on in the same cycle.
`default_nettype none
module serial_motor_command_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  smcd_in_if.sink    rx_i,
  smcd_out_if.source cmd_o
);
  import smcd_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  byte_t       s1_byte_q;
  logic        s1_adv, rx_ready, rx_fire;
  logic        out_valid_q, out_valid_d;

  smcd_frame_t                 frame_nxt;
  logic [MotorCount-1:0]       dir_nxt, dir_q;
  duty_t [MotorCount-1:0]      duty_nxt, duty_q;
  logic                        brake_q, echo_q;

  assign s1_adv   = s1_valid_q && (!out_valid_q || cmd_o.ready);
  assign rx_ready = !s1_valid_q || s1_adv;
  assign rx_fire  = rx_i.valid && rx_ready;
  assign rx_i.ready = rx_ready;

  assign s1_valid_d  = rx_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (cmd_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      s1_byte_q <= rx_i.rx_byte;
    end
    if (s1_adv) begin
      brake_q <= frame_nxt.brake;
      echo_q  <= frame_nxt.echo;
      dir_q   <= dir_nxt;
      duty_q  <= duty_nxt;
    end
  end

  smcd_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_adv),
    .rx_byte_i (s1_byte_q),
    .frame_o   (frame_nxt)
  );

  for (genvar m = 0; m < MotorCount; m++) begin : g_motor
    smcd_duty u_duty (
      .word_i (frame_nxt.words[m]),
      .dir_o  (dir_nxt[m]),
      .duty_o (duty_nxt[m])
    );
  end

  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.brake_active = brake_q;
  assign cmd_o.dir_first    = dir_q[0];
  assign cmd_o.dir_second   = dir_q[1];
  assign cmd_o.dir_third    = dir_q[2];
  assign cmd_o.duty_first   = duty_q[0];
  assign cmd_o.duty_second  = duty_q[1];
  assign cmd_o.duty_third   = duty_q[2];
  assign cmd_o.echo_valid   = echo_q;

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !cmd_o.ready |=> s1_valid_q && $stable(s1_byte_q))
    else $error("byte in stage one lost during output stall");

  a_sync_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_byte_q == SyncByte) |=> out_valid_q && echo_q)
    else $error("sync byte gave no echo");

  a_stop_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_byte_q == StopByte) |=> brake_q)
    else $error("stop byte did not set brake");

  a_not_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready |-> s1_valid_q && out_valid_q)
    else $error("input refused while a stage is free");

endmodule
`default_nettype wire

### rtl/smcd_frame.sv
// Frame state: command decode, byte store, word latch and brake flag.
`default_nettype none
module smcd_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  smcd_pkg::byte_t      rx_byte_i,
  output smcd_pkg::smcd_frame_t frame_o
);
  import smcd_pkg::*;

  logic [PosW-1:0]                  pos_q, pos_d, pos_eff;
  byte_t [FrameLen-1:0]             bytes_q, bytes_d;
  logic [MotorCount-1:0][WordW-1:0] words_q, words_d;
  logic                             brake_q, brake_d;
  logic                             is_go, is_stop, is_sync, is_data, latch;

  assign is_go   = (rx_byte_i == GoByte);
  assign is_stop = (rx_byte_i == StopByte);
  assign is_sync = (rx_byte_i == SyncByte);
  assign is_data = !(is_go || is_stop || is_sync);

  // an out-of-range position counts as the start of a frame
  assign pos_eff = ({1'b0, pos_q} >= (PosW+1)'(FrameLen)) ? '0 : pos_q;

  always_comb begin
    if (is_sync) begin
      pos_d = '0;
    end else if (is_data) begin
      pos_d = (pos_eff == PosW'(FrameLen - 1)) ? '0 : pos_eff + 1'b1;
    end else begin
      pos_d = pos_eff;
    end
  end

  always_comb begin
    for (int k = 0; k < FrameLen; k++) begin
      bytes_d[k] = (is_data && (pos_eff == PosW'(k))) ? rx_byte_i : bytes_q[k];
    end
  end

  // any byte that leaves the position at zero re-latches the words, low byte first
  assign latch = (pos_d == '0);

  always_comb begin
    for (int m = 0; m < MotorCount; m++) begin
      words_d[m] = latch ? {bytes_d[2*m+1], bytes_d[2*m]} : words_q[m];
    end
  end

  always_comb begin
    if (is_go) begin
      brake_d = 1'b0;
    end else if (is_stop) begin
      brake_d = 1'b1;
    end else begin
      brake_d = brake_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bytes_q <= '0;
      words_q <= '0;
      brake_q <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      bytes_q <= bytes_d;
      words_q <= words_d;
      brake_q <= brake_d;
    end
  end

  assign frame_o.brake = brake_d;
  assign frame_o.echo  = is_sync;
  assign frame_o.words = words_d;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (PosW+1)'(FrameLen))
    else $error("frame position out of range");

  a_sync_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_sync |=> (pos_q == '0) && (words_q[0] == {bytes_q[1], bytes_q[0]}))
    else $error("sync byte did not restart and latch the frame");

  a_cmd_keeps_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !is_data |=> $stable(bytes_q))
    else $error("command byte changed the stored frame");

endmodule
`default_nettype wire

### rtl/smcd_duty.sv
// One motor: direction from the sign bit, duty = 5 * magnitude / 3.
`default_nettype none
module smcd_duty (
  input  smcd_pkg::word_t word_i,
  output logic            dir_o,
  output smcd_pkg::duty_t duty_o
);
  import smcd_pkg::*;

  // x / 3 as (x * ceil(2^19 / 3)) >> 19, exact for x below 2^19
  localparam int               RecipShift = 19;
  localparam logic [17:0]      RecipThird = 18'd174763;

  logic [WordW-2:0] mag;
  logic [17:0]      five_mag;
  logic [35:0]      prod;

  assign mag      = word_i[WordW-2:0];
  assign five_mag = {1'b0, mag, 2'b00} + {3'b000, mag};
  assign prod     = five_mag * RecipThird;

  assign dir_o  = ~word_i[WordW-1];
  assign duty_o = prod[RecipShift +: DutyW];

endmodule
`default_nettype wire

### bench/testbench.sv
// Testbench of the serial motor command decoder: byte stimulus, command prediction and checks.
`timescale 1ns / 100ps
module testbench;
  import smcd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 80;
  localparam int MaxGap     = 18;

  typedef struct packed {
    logic                              brake_active;
    logic [MotorCount-1:0]             dir;
    logic [MotorCount-1:0][DutyW-1:0]  duty;
    logic                              echo_valid;
  } motor_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  smcd_in_if  rx_if ();
  smcd_out_if cmd_if ();

  serial_motor_command_decoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .cmd_o  (cmd_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // decoder state as predicted
  int    frame_pos;
  byte_t frame_bytes [FrameLen];
  word_t latched_words [MotorCount];
  logic  brake_flag;

  motor_cmd_t expected_cmds [$];
  string      motor_name [MotorCount] = '{"first", "second", "third"};

  int error_count = 0;
  int sent_count  = 0;
  int cycle_count = 0;
  bit tx_idle_en  = 1'b0;
  bit rx_stall_en = 1'b0;
  bit hold_outputs = 1'b0;

  function automatic int draw_gap(bit enabled);
    if (!enabled) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, MaxGap);
    return 0;
  endfunction

  function automatic motor_cmd_t predict_command(byte_t rx_byte);
    motor_cmd_t  cmd;
    int unsigned mag;
    cmd = '0;
    if (frame_pos >= FrameLen) frame_pos = 0;
    if (rx_byte == GoByte) begin
      brake_flag = 1'b0;
    end else if (rx_byte == StopByte) begin
      brake_flag = 1'b1;
    end else if (rx_byte == SyncByte) begin
      cmd.echo_valid = 1'b1;
      frame_pos = 0;
    end else begin
      frame_bytes[frame_pos] = rx_byte;
      frame_pos++;
      if (frame_pos >= FrameLen) frame_pos = 0;
    end
    // latch also fires on commands that leave the position at zero
    if (frame_pos == 0) begin
      for (int k = 0; k < MotorCount; k++) begin
        latched_words[k] = {frame_bytes[2*k+1], frame_bytes[2*k]};
      end
    end
    cmd.brake_active = brake_flag;
    for (int k = 0; k < MotorCount; k++) begin
      mag = latched_words[k][14:0];
      cmd.dir[k]  = ~latched_words[k][15];
      cmd.duty[k] = duty_t'((5 * mag) / 3);
    end
    return cmd;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // prediction on each accepted byte, comparison on each accepted command
  always @(posedge clk_i) begin
    motor_cmd_t want;
    motor_cmd_t got;
    if (rst_ni && rx_if.valid && rx_if.ready) begin
      expected_cmds.push_back(predict_command(rx_if.rx_byte));
    end
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      if (expected_cmds.size() == 0) begin
        error_count++;
        $error("command item with no byte pending");
      end else begin
        want = expected_cmds.pop_front();
        got.brake_active = cmd_if.brake_active;
        got.dir  = {cmd_if.dir_third, cmd_if.dir_second, cmd_if.dir_first};
        got.duty = {cmd_if.duty_third, cmd_if.duty_second, cmd_if.duty_first};
        got.echo_valid = cmd_if.echo_valid;
        compare_field("brake_active", want.brake_active, got.brake_active);
        for (int k = 0; k < MotorCount; k++) begin
          compare_field({"dir_", motor_name[k]}, want.dir[k], got.dir[k]);
          compare_field({"duty_", motor_name[k]}, want.duty[k], got.duty[k]);
        end
        compare_field("echo_valid", want.echo_valid, got.echo_valid);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // command receiver: random stalls, and one long hold when asked
  initial begin
    int gap;
    cmd_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_outputs) begin
        cmd_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_outputs = 1'b0;
      end else begin
        gap = draw_gap(rx_stall_en);
        if (gap > 0) begin
          cmd_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      cmd_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && cmd_if.valid));
    end
  end

  // valid stays high after the item so a back-to-back byte follows without valid dropping
  task automatic send_byte(byte_t rx_byte);
    int gap;
    gap = draw_gap(tx_idle_en);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= rx_byte;
    do @(posedge clk_i); while (!rx_if.ready);
    sent_count++;
  endtask

  task automatic idle_tx();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    idle_tx();
    while (expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  function automatic byte_t random_data_byte();
    byte_t b;
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h7F;
      3: b = 8'h80;
      default: begin
        do b = byte_t'($urandom_range(0, 255));
        while (b == GoByte || b == StopByte || b == SyncByte);
      end
    endcase
    return b;
  endfunction

  function automatic byte_t noise_byte();
    case ($urandom_range(0, 11))
      0: return GoByte;
      1: return StopByte;
      2: return SyncByte;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_brake_commands();
    send_byte(GoByte);
    send_byte(StopByte);
    send_byte(StopByte);
    send_byte(GoByte);
    send_byte(StopByte);
  endtask

  // words 0x7fff, 0x8000, 0xffff: full duty forward, zero reverse, full reverse
  task automatic test_extreme_words();
    send_byte(SyncByte);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  task automatic test_commands_mid_frame();
    send_byte(8'h01);
    send_byte(StopByte);
    send_byte(8'h02);
    send_byte(GoByte);
    send_byte(8'h03);
    send_byte(8'h04);
    send_byte(8'h05);
    send_byte(8'h06);
  endtask

  // sync partway through re-latches a mix of new and old bytes
  task automatic test_sync_mid_frame();
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(SyncByte);
  endtask

  task automatic test_random_traffic(int count);
    int stop_at;
    int frame_len;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, FrameLen - 1) : FrameLen;
        if ($urandom_range(0, 1)) send_byte(SyncByte);
        for (int k = 0; k < frame_len; k++) begin
          if ($urandom_range(0, 9) == 0) send_byte($urandom_range(0, 1) ? GoByte : StopByte);
          send_byte(random_data_byte());
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(noise_byte());
      end
    end
  endtask

  task automatic test_backpressure();
    hold_outputs = 1'b1;
    test_random_traffic(200);
  endtask

  initial begin
    frame_pos  = 0;
    brake_flag = 1'b0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    foreach (latched_words[i]) latched_words[i] = '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    test_brake_commands();
    test_extreme_words();
    test_commands_mid_frame();
    test_sync_mid_frame();
    test_random_traffic(550);

    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    test_random_traffic(300);
    test_backpressure();
    drain_results();

    tx_idle_en = 1'b1;
    test_random_traffic(250);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b1;
    test_random_traffic(250);
    tx_idle_en = 1'b1;
    test_random_traffic(200);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      error_count++;
      $error("%0d command items never arrived", expected_cmds.size());
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/smcd_pkg.sv
rtl/smcd_intf.sv
rtl/smcd_frame.sv
rtl/smcd_duty.sv
rtl/serial_motor_command_decoder_unit.sv
bench/testbench.sv
